// ===== src/avk_pkg.sv =====
// Package for the altitude/velocity Kalman core.
// Holds fixed-point constants, register indexes and the shared unit operation codes; no dependencies.
package avk_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 31;
    localparam int ACC_W         = 25;
    localparam int BARO_W        = 32;
    localparam int OUT_W         = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TSTEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NALT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NVEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NBARO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INITVAR  = 3'd5;

    localparam logic [30:0] RST_GRAVITY = 31'd642908;
    localparam logic [15:0] RST_TSTEP   = 16'd655;
    localparam logic [30:0] RST_NALT    = 31'd655;
    localparam logic [30:0] RST_NVEL    = 31'd6554;
    localparam logic [30:0] RST_NBARO   = 31'd32768;
    localparam logic [30:0] RST_INITVAR = 31'd655360;

    // Shared unit operations.
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } alu_op_t;

endpackage

// ===== src/avk_if.sv =====
// Valid/ready channel interface used for input and result transfers.
// Depends on nothing; payload width is a parameter.
interface avk_if #(
    parameter int W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/altitude_velocity_kalman_core.sv =====
// Top level of the altitude/velocity Kalman core: registers, state and sequencer.
// Depends on avk_pkg, avk_if and avk_alu.
//
// Usage: one input transfer carries {baro_altitude, accel_z}; one result transfer
// carries {est_velocity, est_altitude}. Both channels are valid/ready.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, which the block itself does not enforce. All arithmetic
// runs through one shared unit stepped by a small microprogram of 27 operations:
// 10 multiplies, 2 divides and 15 adds or subtracts. The block is ready again in
// the cycle after the result transfer. When the innovation variance is not
// positive both divides are skipped.
// The block takes no new item until its result has been transferred.
// Reset restores the default registers and loads the covariance diagonal from
// the initial variance. A stalled receiver simply holds the result register.
module altitude_velocity_kalman_core import avk_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    avk_if.sink                   in_ch,
    avk_if.source                 out_ch
);
    localparam int W = WORD_BITS;
    typedef logic signed [W-1:0] word_t;

    // Register-file slots the microprogram reads and writes.
    typedef enum logic [4:0] {
        R_ALT, R_VEL, R_PAA, R_PAV, R_PVV, R_DT, R_NET, R_ACC, R_Z, R_GRAV,
        R_NA, R_NV, R_NB, R_T0, R_T1, R_M01, R_M00, R_P00, R_P11, R_S, R_K0,
        R_K1, R_Y, R_AP, R_VP, R_ZERO
    } slot_t;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} st_t;

    typedef struct packed {
        alu_op_t op;
        slot_t   a;
        slot_t   b;
        slot_t   d;
    } uop_t;

    localparam int NUOP = 27;

    function automatic uop_t prog(input logic [4:0] i);
        uop_t u;
        u = '{OP_ADD, R_ZERO, R_ZERO, R_ZERO};
        unique case (i)
            5'd0:  u = '{OP_SUB, R_ACC, R_GRAV, R_NET};
            5'd1:  u = '{OP_MUL, R_DT, R_VEL, R_T0};
            5'd2:  u = '{OP_ADD, R_ALT, R_T0, R_AP};
            5'd3:  u = '{OP_MUL, R_DT, R_NET, R_T0};
            5'd4:  u = '{OP_ADD, R_VEL, R_T0, R_VP};
            5'd5:  u = '{OP_MUL, R_DT, R_PVV, R_T0};
            5'd6:  u = '{OP_ADD, R_PAV, R_T0, R_M01};
            5'd7:  u = '{OP_MUL, R_DT, R_PAV, R_T0};
            5'd8:  u = '{OP_ADD, R_PAA, R_T0, R_M00};
            5'd9:  u = '{OP_MUL, R_DT, R_M01, R_T0};
            5'd10: u = '{OP_ADD, R_M00, R_T0, R_T1};
            5'd11: u = '{OP_ADD, R_T1, R_NA, R_P00};
            5'd12: u = '{OP_ADD, R_PVV, R_NV, R_P11};
            5'd13: u = '{OP_SUB, R_Z, R_AP, R_Y};
            5'd14: u = '{OP_ADD, R_P00, R_NB, R_S};
            5'd15: u = '{OP_DIV, R_P00, R_S, R_K0};
            5'd16: u = '{OP_DIV, R_M01, R_S, R_K1};
            5'd17: u = '{OP_MUL, R_K0, R_Y, R_T0};
            5'd18: u = '{OP_ADD, R_AP, R_T0, R_ALT};
            5'd19: u = '{OP_MUL, R_K1, R_Y, R_T0};
            5'd20: u = '{OP_ADD, R_VP, R_T0, R_VEL};
            5'd21: u = '{OP_MUL, R_K0, R_P00, R_T0};
            5'd22: u = '{OP_SUB, R_P00, R_T0, R_PAA};
            5'd23: u = '{OP_MUL, R_K0, R_M01, R_T0};
            5'd24: u = '{OP_SUB, R_M01, R_T0, R_PAV};
            5'd25: u = '{OP_MUL, R_K1, R_M01, R_T0};
            5'd26: u = '{OP_SUB, R_P11, R_T0, R_PVV};
            default: u = '{OP_ADD, R_ZERO, R_ZERO, R_ZERO};
        endcase
        return u;
    endfunction

    // Saturate an unsigned register into the word range.
    function automatic word_t sat_u(input logic [30:0] v);
        logic [63:0] wide;
        logic [63:0] mx;
        wide = 64'(v);
        mx   = 64'((65'd1 << (W - 1)) - 65'd1);
        return (wide > mx) ? word_t'(mx) : word_t'(wide);
    endfunction

    // Saturate a signed value of up to 64 bits into the word range.
    function automatic word_t sat_s(input logic signed [63:0] v);
        logic signed [64:0] mx;
        logic signed [64:0] mn;
        mx = (65'sd1 <<< (W - 1)) - 65'sd1;
        mn = -mx - 65'sd1;
        if (65'(v) > mx) return word_t'(mx);
        if (65'(v) < mn) return word_t'(mn);
        return word_t'(v);
    endfunction

    function automatic logic signed [OUT_W-1:0] out32(input word_t v);
        logic signed [63:0] x;
        x = 64'(v);
        if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[OUT_W-1:0];
    endfunction

    logic [30:0] grav_reg;
    logic [15:0] tstep_reg;
    logic [30:0] nalt_reg;
    logic [30:0] nvel_reg;
    logic [30:0] nbaro_reg;

    word_t rf_reg [0:25];
    st_t        st_reg;
    logic [4:0] pc_reg;
    logic       out_valid_reg;
    logic [2*OUT_W-1:0] out_data_reg;

    uop_t  uop;
    word_t opa;
    word_t opb;
    logic  alu_start;
    logic  alu_done;
    word_t alu_res;
    logic  skip_div;

    assign uop = prog(pc_reg);
    assign opa = rf_reg[uop.a];
    assign opb = rf_reg[uop.b];
    // Nonpositive innovation variance: gains forced to zero.
    assign skip_div = (uop.op == OP_DIV) && (rf_reg[R_S] <= 0);
    assign alu_start = (st_reg == S_ISSUE) && !skip_div;

    avk_alu #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .op     (uop.op),
        .a      (opa),
        .b      (opb),
        .done   (alu_done),
        .result (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            grav_reg    <= RST_GRAVITY;
            tstep_reg   <= RST_TSTEP;
            nalt_reg    <= RST_NALT;
            nvel_reg    <= RST_NVEL;
            nbaro_reg   <= RST_NBARO;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GRAVITY: grav_reg    <= cfg_data;
                REG_TSTEP:   tstep_reg   <= cfg_data[15:0];
                REG_NALT:    nalt_reg    <= cfg_data;
                REG_NVEL:    nvel_reg    <= cfg_data;
                REG_NBARO:   nbaro_reg   <= cfg_data;
                // The initial variance is read only at reset, which restores its default.
                REG_INITVAR: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            st_reg        <= S_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 26; i++)
                rf_reg[i] <= (i == R_PAA || i == R_PVV) ? sat_u(RST_INITVAR) : '0;
        end else begin
            unique case (st_reg)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        rf_reg[R_ACC]  <= sat_s(64'($signed(in_ch.data[ACC_W-1:0])));
                        rf_reg[R_Z]    <= sat_s(64'($signed(in_ch.data[ACC_W +: BARO_W])));
                        rf_reg[R_DT]   <= sat_u(31'(tstep_reg));
                        rf_reg[R_GRAV] <= sat_u(grav_reg);
                        rf_reg[R_NA]   <= sat_u(nalt_reg);
                        rf_reg[R_NV]   <= sat_u(nvel_reg);
                        rf_reg[R_NB]   <= sat_u(nbaro_reg);
                        pc_reg         <= '0;
                        st_reg         <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (skip_div) begin
                        rf_reg[uop.d] <= '0;
                        pc_reg        <= pc_reg + 5'd1;
                    end else begin
                        st_reg <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (alu_done) begin
                        rf_reg[uop.d] <= alu_res;
                        if (pc_reg == 5'(NUOP - 1)) begin
                            st_reg <= S_OUT;
                        end else begin
                            pc_reg <= pc_reg + 5'd1;
                            st_reg <= S_ISSUE;
                        end
                    end
                end
                S_OUT: begin
                    if (!out_valid_reg) begin
                        out_data_reg  <= {out32(rf_reg[R_VEL]), out32(rf_reg[R_ALT])};
                        out_valid_reg <= 1'b1;
                    end else if (out_ch.ready) begin
                        out_valid_reg <= 1'b0;
                        st_reg        <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ch.ready  = (st_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
    a_start_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> (st_reg == S_ISSUE && pc_reg == '0))
        else $error("sequencer did not start");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(st_reg == S_OUT)) else $error("stray result");
endmodule

// ===== src/avk_alu.sv =====
// Shared arithmetic unit: saturating add/sub, rounded multiply, rounded divide.
// Depends on avk_pkg. Multiply and divide iterate one bit per cycle.
module avk_alu import avk_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  alu_op_t                     op,
    input  logic signed [WORD_BITS-1:0] a,
    input  logic signed [WORD_BITS-1:0] b,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] result
);
    localparam int W  = WORD_BITS;
    localparam int PW = 2 * WORD_BITS + 2;
    localparam int CW = $clog2(PW + 1);
    localparam logic [W:0] MAXM = {2'b00, {(W-1){1'b1}}};

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} st_t;

    st_t              st_reg;
    logic             neg_reg;
    logic [W-1:0]     ma_reg;
    logic [W-1:0]     mb_reg;
    logic [PW-1:0]    acc_reg;
    logic [PW-1:0]    rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic [PW-1:0]    mag_reg;
    logic             done_reg;
    logic signed [W-1:0] res_reg;

    logic [W-1:0] amag;
    logic [W-1:0] bmag;
    logic signed [W:0] sum;
    logic [PW-1:0] rem_sh;
    logic          q_bit;
    logic [PW-1:0] rounded;
    logic [W:0]    lim;
    logic [W-1:0]  satm;

    assign amag = a[W-1] ? W'(-a) : W'(a);
    assign bmag = b[W-1] ? W'(-b) : W'(b);
    assign sum  = (op == OP_SUB) ? ($signed({a[W-1], a}) - $signed({b[W-1], b}))
                                 : ($signed({a[W-1], a}) + $signed({b[W-1], b}));
    assign rem_sh = {rem_reg[PW-2:0], acc_reg[PW-1]};
    assign q_bit  = (rem_sh >= PW'(mb_reg));
    // Product is rounded on magnitude at FRAC_BITS; quotient carries one extra bit.
    assign rounded = (st_reg == S_FIN && cnt_reg == '0)
                   ? ((mag_reg + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS)
                   : ((mag_reg + PW'(1)) >> 1);
    assign lim  = neg_reg ? MAXM + (W+1)'(1) : MAXM;
    assign satm = (rounded > PW'(lim)) ? W'(lim) : W'(rounded);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE: begin
                    if (start) begin
                        // A quotient takes the sign of the numerator only.
                        neg_reg <= (op == OP_DIV) ? a[W-1] : (a[W-1] ^ b[W-1]);
                        ma_reg  <= amag;
                        mb_reg  <= bmag;
                        unique case (op)
                            OP_ADD, OP_SUB: begin
                                if (sum > $signed({2'b00, {(W-1){1'b1}}}))
                                    res_reg <= {1'b0, {(W-1){1'b1}}};
                                else if (sum < $signed({2'b11, {(W-1){1'b0}}}))
                                    res_reg <= {1'b1, {(W-1){1'b0}}};
                                else
                                    res_reg <= W'(sum);
                                done_reg <= 1'b1;
                            end
                            OP_MUL: begin
                                acc_reg <= '0;
                                cnt_reg <= CW'(W);
                                st_reg  <= S_MUL;
                            end
                            OP_DIV: begin
                                // Numerator sits at the top; the zeros shifted in below it
                                // scale it by 2^(FRAC_BITS+1).
                                acc_reg <= PW'(amag) << (PW - W);
                                rem_reg <= '0;
                                cnt_reg <= CW'(W + FRAC_BITS + 1);
                                st_reg  <= S_DIV;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    acc_reg <= (acc_reg << 1) + (mb_reg[W-1] ? PW'(ma_reg) : '0);
                    mb_reg  <= mb_reg << 1;
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        st_reg  <= S_FIN;
                        mag_reg <= (acc_reg << 1) + (mb_reg[W-1] ? PW'(ma_reg) : '0);
                    end
                end
                S_DIV: begin
                    acc_reg <= {acc_reg[PW-2:0], 1'b0};
                    if (q_bit)
                        rem_reg <= rem_sh - PW'(mb_reg);
                    else
                        rem_reg <= rem_sh;
                    if (cnt_reg == CW'(W + FRAC_BITS + 1))
                        mag_reg <= {{(PW-1){1'b0}}, q_bit};
                    else
                        mag_reg <= {mag_reg[PW-2:0], q_bit};
                    if (cnt_reg == CW'(1)) begin
                        st_reg  <= S_FIN;
                        cnt_reg <= CW'(1);
                    end else begin
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                S_FIN: begin
                    res_reg  <= neg_reg ? W'(-satm) : W'(satm);
                    done_reg <= 1'b1;
                    cnt_reg  <= '0;
                    st_reg   <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done || $past(start)) else $error("done held without start");
    a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !done) else $error("done while busy");
    a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_FIN) |=> done) else $error("finish without done");
endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for altitude_velocity_kalman_core.
// Depends on avk_pkg, avk_if and the core; a fixed-point Kalman predictor checks every result.
`timescale 1ns / 100ps

module tb;
    import avk_pkg::*;

    localparam int  IN_W       = ACC_W + BARO_W;
    localparam int  RES_W      = 2 * OUT_W;
    localparam int  WATCHDOG   = 20000;
    localparam int  PHASES     = 8;
    localparam int  PHASE_LEN  = 125;
    localparam longint W_MAX   = 64'sd2147483647;
    localparam longint W_MIN   = -64'sd2147483648;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

    typedef struct {
        logic signed [OUT_W-1:0] alt;
        logic signed [OUT_W-1:0] vel;
    } estimate_t;

    typedef struct {
        logic signed [ACC_W-1:0]  accel;
        logic signed [BARO_W-1:0] baro;
    } sample_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    avk_if #(.W(IN_W))  in_ch ();
    avk_if #(.W(RES_W)) out_ch ();

    altitude_velocity_kalman_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // Shadow copy of the registers and the filter state.
    longint gravity_r, dt_r, q_alt_r, q_vel_r, r_baro_r, init_var_r;
    longint alt_s, vel_s, p00_s, p01_s, p11_s;

    estimate_t estimate_q[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        stall_left = 0;
    bit        res_taken;
    bit        stall_enable;
    bit        gap_enable;
    bit        timed_out = 1'b0;
    longint    baro_track;

    sample_t directed_rows[] = '{
        '{25'sd0,        32'sd0},
        '{25'sd642908,   32'sd0},
        '{25'sd10485759, 32'sd2147483647},
        '{-25'sd10485760, -32'sd2147483648},
        '{25'sd10485759, -32'sd2147483648},
        '{-25'sd10485760, 32'sd2147483647},
        '{25'sd0,        32'sd65536},
        '{-25'sd1,       -32'sd1},
        '{25'sd642908,   32'sd655360},
        '{25'sd700000,   32'sd660000},
        '{25'sd600000,   32'sd640000},
        '{25'sd5592405,  32'sh55555555},
        '{-25'sd5592406, -32'sh55555556},
        '{25'sd642908,   32'sd0}
    };

    // Fixed-point helpers at a 32-bit word with 16 fraction bits.
    function automatic longint sat_w(longint v);
        if (v > W_MAX)
            return W_MAX;
        if (v < W_MIN)
            return W_MIN;
        return v;
    endfunction

    function automatic longint from_mag(bit neg, longint unsigned m);
        longint unsigned lim;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (m > lim)
            m = lim;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint mul_q(longint a, longint b);
        bit              neg;
        longint unsigned ua, ub, prod;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? -a : a;
        ub   = (b < 0) ? -b : b;
        prod = ua * ub + 64'd32768;
        return from_mag(neg, prod >> 16);
    endfunction

    function automatic longint div_q(longint p, longint s);
        bit              neg;
        longint unsigned num, q, rem, f, lim;
        neg = p < 0;
        num = neg ? -p : p;
        q   = num / s;
        rem = num % s;
        f   = 0;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (q > (lim >> 16))
            return from_mag(neg, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i <= 16; i++) begin
            rem = rem << 1;
            f   = f << 1;
            if (rem >= s) begin
                rem = rem - s;
                f   = f | 1;
            end
        end
        return from_mag(neg, (q << 16) + ((f + 1) >> 1));
    endfunction

    // One predict/correct cycle of the filter; returns the updated estimate.
    function automatic estimate_t kalman_update(sample_t smp);
        longint    net, alt_p, vel_p, m00, m01, p00, p01, p11, innov, s, k0, k1;
        estimate_t est;
        net   = sat_w(longint'(smp.accel) - gravity_r);
        alt_p = sat_w(alt_s + mul_q(dt_r, vel_s));
        vel_p = sat_w(vel_s + mul_q(dt_r, net));
        m01   = sat_w(p01_s + mul_q(dt_r, p11_s));
        m00   = sat_w(p00_s + mul_q(dt_r, p01_s));
        p00   = sat_w(sat_w(m00 + mul_q(dt_r, m01)) + q_alt_r);
        p01   = m01;
        p11   = sat_w(p11_s + q_vel_r);
        innov = sat_w(longint'(smp.baro) - alt_p);
        s     = sat_w(p00 + r_baro_r);
        k0    = 0;
        k1    = 0;
        // A nonpositive innovation variance leaves the prediction uncorrected.
        if (s > 0) begin
            k0 = div_q(p00, s);
            k1 = div_q(p01, s);
        end
        alt_s   = sat_w(alt_p + mul_q(k0, innov));
        vel_s   = sat_w(vel_p + mul_q(k1, innov));
        p00_s   = sat_w(p00 - mul_q(k0, p00));
        p01_s   = sat_w(p01 - mul_q(k0, p01));
        p11_s   = sat_w(p11 - mul_q(k1, p01));
        est.alt = alt_s[31:0];
        est.vel = vel_s[31:0];
        return est;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    endtask

    // Register write; the shadow copy follows the same masking as the block.
    // The caller drops the write enable after the last write of a sequence.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_GRAVITY: gravity_r  = value;
            REG_TSTEP:   dt_r       = value[15:0];
            REG_NALT:    q_alt_r    = value;
            REG_NVEL:    q_vel_r    = value;
            REG_NBARO:   r_baro_r   = value;
            REG_INITVAR: init_var_r = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Drives one sample; called at a falling edge and returns at a falling edge.
    task automatic send_sample(sample_t smp, int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {smp.baro, smp.accel};
        do
            @(posedge clk);
        while (!in_ch.ready);
        estimate_q.push_back(kalman_update(smp));
        @(negedge clk);
    endtask

    function automatic int draw_gap();
        return gap_enable ? $urandom_range(0, 18) : 0;
    endfunction

    // Mostly a plausible flight: accel near gravity, baro drifting slowly.
    // The rest is full-range noise on both fields.
    function automatic sample_t draw_sample();
        sample_t smp;
        longint  acc;
        if ($urandom_range(0, 9) < 8) begin
            acc        = gravity_r + $signed($urandom_range(0, 400000)) - 200000;
            if (acc > 10485759)
                acc = 10485759;
            if (acc < -10485760)
                acc = -10485760;
            baro_track = sat_w(baro_track + $signed($urandom_range(0, 131072)) - 65536);
            smp.accel  = acc[ACC_W-1:0];
            smp.baro   = baro_track[31:0];
        end else begin
            smp.accel = ACC_W'($urandom());
            smp.baro  = $urandom();
        end
        return smp;
    endfunction

    // Picks a register value: one extreme or the other, or else any random value of the field.
    function automatic logic [CFG_DATA_W-1:0] draw_reg(longint lo, longint hi, bit extremes);
        if (extremes)
            return ($urandom_range(0, 1) != 0) ? hi[CFG_DATA_W-1:0] : lo[CFG_DATA_W-1:0];
        return CFG_DATA_W'($urandom());
    endfunction

    task automatic wait_idle();
        while (estimate_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side: the ready stall count is drawn again after every transfer.
    always @(negedge clk) begin
        int n;
        n = stall_left;
        if (res_taken)
            n = stall_enable ? $urandom_range(0, 18) : 0;
        if (n > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= n - 1;
        end else begin
            out_ch.ready <= 1'b1;
            stall_left   <= 0;
        end
    end

    always @(posedge clk) begin
        estimate_t want;
        res_taken <= out_ch.valid && out_ch.ready;
        if (out_ch.valid && out_ch.ready) begin
            if (estimate_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: result transfer with nothing expected", $realtime);
            end else begin
                want = estimate_q.pop_front();
                if (out_ch.data[31:0] !== want.alt)
                    report_mismatch("est_altitude", out_ch.data[31:0], want.alt);
                if (out_ch.data[63:32] !== want.vel)
                    report_mismatch("est_velocity", out_ch.data[63:32], want.vel);
            end
        end
    end

    // Watchdog: any cycle with a transfer on either channel restarts the count.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        bit extremes;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        stall_enable   = 1'b1;
        gap_enable     = 1'b1;
        baro_track     = 0;

        // Reset defaults; the covariance diagonal starts from the initial variance.
        gravity_r  = RST_GRAVITY;
        dt_r       = RST_TSTEP;
        q_alt_r    = RST_NALT;
        q_vel_r    = RST_NVEL;
        r_baro_r   = RST_NBARO;
        init_var_r = RST_INITVAR;
        alt_s      = 0;
        vel_s      = 0;
        p00_s      = init_var_r;
        p01_s      = 0;
        p11_s      = init_var_r;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed rows at the reset settings: field extremes and a resting sensor.
        foreach (directed_rows[i])
            send_sample(directed_rows[i], draw_gap());
        in_ch.valid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            // The first two phases use extreme settings, later ones mix random values in.
            extremes = (ph < 2) || ($urandom_range(0, 2) == 0);
            if (ph == PHASES - 1) begin
                // Back to realistic values so the filter settles again.
                write_reg(REG_GRAVITY, RST_GRAVITY);
                write_reg(REG_TSTEP, RST_TSTEP);
                write_reg(REG_NALT, RST_NALT);
                write_reg(REG_NVEL, RST_NVEL);
                write_reg(REG_NBARO, RST_NBARO);
            end else begin
                write_reg(REG_GRAVITY, draw_reg(0, 2147483647, extremes));
                write_reg(REG_TSTEP, (ph == 0) ? 31'd1 : (ph == 1) ? 31'h7FFF_FFFF
                                                                   : draw_reg(1, 65535, extremes));
                write_reg(REG_NALT, draw_reg(0, 2147483647, extremes));
                write_reg(REG_NVEL, draw_reg(0, 2147483647, extremes));
                write_reg(REG_NBARO, (ph == 0) ? 31'd1 : draw_reg(1, 2147483647, extremes));
                if (r_baro_r == 0)
                    write_reg(REG_NBARO, 31'd1);
            end
            // The initial variance is only loaded at reset, so this must not disturb state.
            write_reg(REG_INITVAR, draw_reg(0, 2147483647, extremes));
            // Indexes past the last register are ignored.
            write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
            write_reg(REG_SPARE + 3'd1, CFG_DATA_W'($urandom()));
            cfg_we <= 1'b0;

            gap_enable   = (ph % 3) != 1;
            stall_enable = (ph % 4) != 2;
            for (int n = 0; n < PHASE_LEN; n++)
                send_sample(draw_sample(), draw_gap());
            in_ch.valid <= 1'b0;
        end

        while (estimate_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
